// File: rtl/swmf_pkg.sv
// Shared types and constants for the sliding window median filter.
`default_nettype none

package swmf_pkg;

    localparam int WINDOW_MAX_DEF = 15;
    localparam int SIZE_AT_RESET  = 5;
    localparam int SAMPLE_W       = 16;
    localparam int AGE_W          = 8;
    localparam int SIZE_W         = 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_REPL,
        S_RANK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic srch;
        logic repl;
        logic rank;
        logic out_load;
    } t_ctl;

endpackage

`default_nettype wire

// File: rtl/sliding_window_median_filter.sv
// Top level of the sliding window median filter: cell row, sequencer and output register.
// Each sample takes two trips round the cell ring, one to find the oldest entry and one to rank
// the values; the input stays stalled until the median is loaded into the output register.
// A new sample is taken while an earlier median still waits at the output.
// Synchronous active-low reset clears the samples, sets entry ages to their index
// and the window size to five.
`default_nettype none

module sliding_window_median_filter #(
    parameter int WINDOW_MAX = swmf_pkg::WINDOW_MAX_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire  [swmf_pkg::SIZE_W-1:0]    i_cfg_wdata,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire  [swmf_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [swmf_pkg::SAMPLE_W-1:0]  o_median
);
    import swmf_pkg::*;

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SZ_CW = (SIZE_W > 7) ? SIZE_W : 7;
    localparam logic [SIZE_W-1:0] SIZE_RST =
        (SIZE_AT_RESET <= WINDOW_MAX) ? SIZE_W'(SIZE_AT_RESET) : SIZE_W'(WINDOW_MAX);

    logic [SIZE_W-1:0]   r_size;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_median;
    logic [SAMPLE_W-1:0] n_median;
    logic                out_pending;
    t_ctl                ctl;

    logic [SAMPLE_W-1:0] pass_value [WINDOW_MAX];
    logic [AGE_W-1:0]    pass_age   [WINDOW_MAX];
    logic [IDX_W-1:0]    pass_idx   [WINDOW_MAX];
    logic [SAMPLE_W-1:0] pick_value [WINDOW_MAX];

    assign out_pending = r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RST;
        end else if (i_cfg_we && (i_cfg_wdata != '0)
                     && (SZ_CW'(i_cfg_wdata) <= SZ_CW'(WINDOW_MAX))) begin
            r_size <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.accept) begin
            r_sample <= i_sample;
        end
    end

    swmf_ctrl #(
        .WINDOW_MAX (WINDOW_MAX),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_out_pending (out_pending),
        .o_in_stall    (o_in_stall),
        .o_ctl         (ctl)
    );

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        localparam int NB = (g + 1) % WINDOW_MAX;
        swmf_cell #(
            .WINDOW_MAX (WINDOW_MAX),
            .INDEX      (g),
            .IDX_W      (IDX_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_size       (r_size),
            .i_sample     (r_sample),
            .i_nb_value   (pass_value[NB]),
            .i_nb_age     (pass_age[NB]),
            .i_nb_idx     (pass_idx[NB]),
            .o_pass_value (pass_value[g]),
            .o_pass_age   (pass_age[g]),
            .o_pass_idx   (pass_idx[g]),
            .o_pick_value (pick_value[g])
        );
    end

    always_comb begin
        n_median = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            n_median = n_median | pick_value[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.out_load) begin
            r_median <= n_median;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_median    = r_median;

endmodule

`default_nettype wire

// File: rtl/swmf_cell.sv
// One window entry with its sample, its age and a slot of the rotating compare ring.
`default_nettype none

module swmf_cell #(
    parameter int WINDOW_MAX = 15,
    parameter int INDEX      = 0,
    parameter int IDX_W      = 4
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  swmf_pkg::t_ctl                    i_ctl,
    input  wire  [swmf_pkg::SIZE_W-1:0]       i_size,
    input  wire  [swmf_pkg::SAMPLE_W-1:0]     i_sample,
    input  wire  [swmf_pkg::SAMPLE_W-1:0]     i_nb_value,
    input  wire  [swmf_pkg::AGE_W-1:0]        i_nb_age,
    input  wire  [IDX_W-1:0]                  i_nb_idx,
    output logic [swmf_pkg::SAMPLE_W-1:0]     o_pass_value,
    output logic [swmf_pkg::AGE_W-1:0]        o_pass_age,
    output logic [IDX_W-1:0]                  o_pass_idx,
    output logic [swmf_pkg::SAMPLE_W-1:0]     o_pick_value
);
    import swmf_pkg::*;

    localparam int CW = (IDX_W > SIZE_W) ? IDX_W : SIZE_W;
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [SAMPLE_W-1:0] r_value;
    logic [AGE_W-1:0]    r_age;
    logic                r_beaten;
    logic [IDX_W-1:0]    r_cnt;
    logic [SAMPLE_W-1:0] r_pv;
    logic [AGE_W-1:0]    r_pa;
    logic [IDX_W-1:0]    r_pidx;

    logic                in_win;
    logic                pass_in_win;
    logic                is_pick;
    logic                age_beats;
    logic                value_below;
    logic [AGE_W-1:0]    n_age_inc;

    always_comb begin
        in_win      = CW'(MY_IDX) < CW'(i_size);
        pass_in_win = CW'(r_pidx) < CW'(i_size);
        is_pick     = in_win && !r_beaten;
        n_age_inc   = r_age + AGE_W'(1);
        age_beats   = (r_pa > r_age) || ((r_pa == r_age) && (r_pidx < MY_IDX));
        value_below = (r_pv < r_value) || ((r_pv == r_value) && (r_pidx < MY_IDX));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
            r_age   <= AGE_W'(INDEX);
        end else if (i_ctl.accept) begin
            if (in_win) begin
                r_age <= n_age_inc;
            end
        end else if (i_ctl.repl) begin
            if (is_pick) begin
                r_value <= i_sample;
                r_age   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_pv     <= r_value;
            r_pa     <= in_win ? n_age_inc : r_age;
            r_pidx   <= MY_IDX;
            r_beaten <= 1'b0;
        end else if (i_ctl.srch) begin
            if (pass_in_win && age_beats) begin
                r_beaten <= 1'b1;
            end
            r_pv   <= i_nb_value;
            r_pa   <= i_nb_age;
            r_pidx <= i_nb_idx;
        end else if (i_ctl.repl) begin
            r_pv   <= is_pick ? i_sample : r_value;
            r_pidx <= MY_IDX;
            r_cnt  <= '0;
        end else if (i_ctl.rank) begin
            if (pass_in_win && value_below) begin
                r_cnt <= r_cnt + IDX_W'(1);
            end
            r_pv   <= i_nb_value;
            r_pa   <= i_nb_age;
            r_pidx <= i_nb_idx;
        end
    end

    assign o_pass_value = r_pv;
    assign o_pass_age   = r_pa;
    assign o_pass_idx   = r_pidx;
    assign o_pick_value = (in_win && (CW'(r_cnt) == CW'(i_size >> 1))) ? r_value : '0;

endmodule

`default_nettype wire

// File: rtl/swmf_ctrl.sv
// Sequencer that steps the cell row through aging, search, replacement, ranking and output loading.
`default_nettype none

module swmf_ctrl #(
    parameter int WINDOW_MAX = 15,
    parameter int IDX_W      = 4
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    input  wire             i_out_pending,
    output logic            o_in_stall,
    output swmf_pkg::t_ctl  o_ctl
);
    import swmf_pkg::*;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(WINDOW_MAX - 1);

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_cnt;
    logic             last;

    assign last = (r_cnt == LAST);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (last) begin
                    n_state = S_REPL;
                end
            end
            S_REPL: begin
                n_state = S_RANK;
            end
            S_RANK: begin
                if (last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_out_pending) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall   = 1'b0;
                o_ctl.accept = i_in_valid;
            end
            S_SRCH: o_ctl.srch = 1'b1;
            S_REPL: o_ctl.repl = 1'b1;
            S_RANK: o_ctl.rank = 1'b1;
            S_OUT:  o_ctl.out_load = !i_out_pending;
            default: o_ctl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_SRCH) || (r_state == S_RANK)) begin
                r_cnt <= last ? '0 : r_cnt + IDX_W'(1);
            end else begin
                r_cnt <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/swmf_checker.sv
// Port-level checks on the sliding window median filter, bound to the top level.
`default_nettype none

module swmf_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        o_in_stall,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire [15:0] o_median
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("Reset did not leave the output empty and the input open.");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("A second sample was taken straight after an input transfer.");

    a_result_opens_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall)
        else $error("A new median appeared while the input stayed stalled.");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid && $stable(o_median))
        else $error("A stalled median changed or vanished.");

endmodule

bind sliding_window_median_filter swmf_checker u_swmf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_median    (o_median)
);

`default_nettype wire

// File: tb/median_checker.sv
// Checker for the sliding window median filter: watches the channels, predicts each median and compares.
`timescale 1ns / 100ps

module median_checker #(
    parameter int WMAX = swmf_pkg::WINDOW_MAX_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire  [swmf_pkg::SIZE_W-1:0]    i_cfg_wdata,
    input  wire                            i_in_valid,
    input  wire                            i_in_stall,
    input  wire  [swmf_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire                            i_out_valid,
    input  wire                            i_out_stall,
    input  wire  [swmf_pkg::SAMPLE_W-1:0]  i_median,
    output int                             o_fail_count,
    output int                             o_pending
);

    logic [swmf_pkg::SAMPLE_W-1:0] win_val [WMAX];
    logic [swmf_pkg::AGE_W-1:0]    win_age [WMAX];
    int                            win_size;
    logic [swmf_pkg::SAMPLE_W-1:0] median_q [$];
    logic [swmf_pkg::SAMPLE_W-1:0] expected_median;

    // Ages the window, replaces its oldest entry with the new sample and returns the median.
    function automatic logic [swmf_pkg::SAMPLE_W-1:0] insert_and_rank(
        input logic [swmf_pkg::SAMPLE_W-1:0] smp
    );
        int                            n;
        int                            k;
        int                            m;
        int                            pick;
        logic [swmf_pkg::AGE_W-1:0]    oldest;
        logic [swmf_pkg::SAMPLE_W-1:0] ranked [WMAX];
        logic [swmf_pkg::SAMPLE_W-1:0] v;
        begin
            n = (win_size < 1) ? 1 : ((win_size > WMAX) ? WMAX : win_size);
            for (k = 0; k < n; k++) begin
                win_age[k] = win_age[k] + 1'b1;
            end
            pick   = 0;
            oldest = win_age[0];
            for (k = 1; k < n; k++) begin
                if (win_age[k] > oldest) begin
                    oldest = win_age[k];
                    pick   = k;
                end
            end
            win_val[pick] = smp;
            win_age[pick] = '0;
            for (k = 0; k < n; k++) begin
                v = win_val[k];
                m = k;
                while (m > 0 && ranked[m-1] > v) begin
                    ranked[m] = ranked[m-1];
                    m--;
                end
                ranked[m] = v;
            end
            return ranked[n/2];
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WMAX; k++) begin
                win_val[k] = '0;
                win_age[k] = k[swmf_pkg::AGE_W-1:0];
            end
            win_size = (swmf_pkg::SIZE_AT_RESET <= WMAX) ? swmf_pkg::SIZE_AT_RESET : WMAX;
            median_q.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (median_q.size() == 0) begin
                    $error("median transfer with none expected: actual %0d", i_median);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    expected_median = median_q.pop_front();
                    if (i_median !== expected_median) begin
                        $error("median mismatch: expected %0d, actual %0d",
                               expected_median, i_median);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_cfg_we && i_cfg_wdata >= 1 && i_cfg_wdata <= WMAX) begin
                win_size = int'(i_cfg_wdata);
            end
            if (i_in_valid && !i_in_stall) begin
                median_q.push_back(insert_and_rank(i_sample));
            end
            o_pending <= median_q.size();
        end
    end

endmodule

// File: tb/sliding_window_median_filter_tb.sv
// Testbench top for the sliding window median filter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module sliding_window_median_filter_tb;
    import swmf_pkg::*;

    localparam int SETTLE      = 2 * swmf_pkg::WINDOW_MAX_DEF + 8;
    localparam int ITEM_TARGET = 1850;
    localparam int CALM_AFTER  = 1700;
    localparam int HOLD_CYCLES = 250;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [swmf_pkg::SIZE_W-1:0]    i_cfg_wdata;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic [swmf_pkg::SAMPLE_W-1:0]  i_sample;
    logic                           o_out_valid;
    logic                           i_out_stall;
    logic [swmf_pkg::SAMPLE_W-1:0]  o_median;

    int                             fail_count;
    int                             pending;
    bit                             idle_on;
    bit                             hold_go;
    bit                             hold_seen;
    int                             hold_left;
    int                             stall_left;
    int                             sent;
    int                             phase;
    int                             phase_len;
    logic [swmf_pkg::SAMPLE_W-1:0]  base;
    logic [swmf_pkg::SAMPLE_W-1:0]  prev;
    logic [swmf_pkg::SAMPLE_W-1:0]  v;

    sliding_window_median_filter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_median    (o_median)
    );

    median_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_sample     (i_sample),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_median     (o_median),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #8_000_000;
        $display("FAILURE");
        $finish;
    end

    // The receiver stalls in short bursts, or for a long stretch when the stimulus asks for one.
    initial begin
        i_out_stall = 1'b0;
        hold_seen   = 1'b0;
        hold_left   = 0;
        stall_left  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_go) begin
                hold_seen = hold_go;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                stall_left = $urandom_range(0, 4);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_sample(input logic [swmf_pkg::SAMPLE_W-1:0] value);
        while (idle_on && $urandom_range(0, 2) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= value;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        prev = value;
        sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_size(input logic [swmf_pkg::SIZE_W-1:0] size_val);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= size_val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_sample    = '0;
        idle_on     = 1'b1;
        hold_go     = 1'b0;
        sent        = 0;
        prev        = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        drain();
        write_size(4'd1);
        send_sample(16'hAAAA);
        send_sample(16'h5555);
        drain();
        write_size(4'd15);
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        send_sample(16'hFFFE);
        send_sample(16'h0000);
        drain();
        write_size(4'd0);
        send_sample(16'h1234);
        send_sample(16'hEDCB);
        drain();
        write_size(4'd2);
        send_sample(16'h0F0F);
        send_sample(16'hF0F0);
        send_sample(16'h0F0F);

        phase = 0;
        while (sent < ITEM_TARGET) begin
            drain();
            case ($urandom_range(0, 5))
                0:       write_size(4'd1);
                1:       write_size(4'd15);
                2:       write_size(4'd0);
                default: write_size(SIZE_W'($urandom_range(1, 15)));
            endcase
            if (phase == 3) begin
                hold_go = ~hold_go;
            end
            idle_on   = (sent < CALM_AFTER);
            base      = SAMPLE_W'($urandom);
            phase_len = $urandom_range(20, 120);
            for (int k = 0; k < phase_len; k++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: v = SAMPLE_W'($urandom);
                    6, 7:             v = base + SAMPLE_W'($urandom_range(0, 7));
                    8:                v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    default:          v = prev;
                endcase
                send_sample(v);
            end
            phase++;
        end

        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
